// File: rtl/mer_pkg.sv
`timescale 1ns / 1ps

package mer_pkg;

	// Radius width default; the top level carries the real parameter
	localparam int RADIUS_BITS_DEF = 8;

	// Output coordinate and config register widths
	localparam int PIX_W     = 11;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int BEAT_W    = 2;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 2'd2;

	localparam logic [CFG_W-1:0] SCREEN_OFFSET_RST = 9'd250;

	// Input action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// Fourth mirror pixel of a step
	localparam logic [BEAT_W-1:0] LAST_BEAT = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_R1,
		PH_R2,
		PH_DONE
	} phase_t;

	// Operand pairs of the shared multiplier
	typedef enum logic [2:0] {
		MUL_RXRX,
		MUL_RYRY,
		MUL_RX2RY,
		MUL_TT,
		MUL_RY2TT,
		MUL_UU,
		MUL_RX2UU,
		MUL_RX2RY2
	} mul_sel_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_ST_M1,
		CS_ST_M2,
		CS_ST_M3,
		CS_ST_INIT,
		CS_ST_EMIT,
		CS_R2_M1,
		CS_R2_M2,
		CS_R2_M3,
		CS_R2_M4,
		CS_R2_M5,
		CS_R2_INIT,
		CS_ITER,
		CS_EMIT,
		CS_FIN
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic              in_load;
		mul_sel_t          mul_sel;
		logic              cap_rx2;
		logic              cap_ry2;
		logic              acc_load;
		logic              acc_add;
		logic              start_init;
		logic              r2_init;
		logic              iter;
		logic              set_done;
		logic              out_load;
		logic              out_fin;
		logic              out_last;
		logic [BEAT_W-1:0] beat;
	} mer_cmd_t;

	// Datapath to controller
	typedef struct packed {
		phase_t phase;
		logic   px_lt_py;
		logic   y_pos;
		logic   out_free;
	} mer_status_t;

endpackage

// File: rtl/mer_ctrl.sv
`timescale 1ns / 1ps

module mer_ctrl import mer_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        action,
	output logic        cmd_ready,
	input  mer_status_t status,
	output mer_cmd_t    cmd
);

	ctrl_state_t       state_q, state_d;
	logic [BEAT_W-1:0] beat_q, beat_d;

	// State and beat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			beat_q  <= '0;
		end else begin
			state_q <= state_d;
			beat_q  <= beat_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		beat_d    = beat_q;
		cmd_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			CS_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (action == ACT_START) begin
						cmd.in_load = 1'b1;
						state_d     = CS_ST_M1;
					end else begin
						unique case (status.phase)
							PH_R1:   state_d = status.px_lt_py ? CS_ITER : CS_R2_M1;
							PH_R2:   state_d = status.y_pos ? CS_ITER : CS_FIN;
							default: state_d = CS_FIN;
						endcase
					end
				end
			end
			// start: rx^2, ry^2, rx^2*ry
			CS_ST_M1: begin
				cmd.mul_sel = MUL_RXRX;
				state_d     = CS_ST_M2;
			end
			CS_ST_M2: begin
				cmd.cap_rx2 = 1'b1;
				cmd.mul_sel = MUL_RYRY;
				state_d     = CS_ST_M3;
			end
			CS_ST_M3: begin
				cmd.cap_ry2 = 1'b1;
				cmd.mul_sel = MUL_RX2RY;
				state_d     = CS_ST_INIT;
			end
			CS_ST_INIT: begin
				cmd.start_init = 1'b1;
				state_d        = CS_ST_EMIT;
			end
			CS_ST_EMIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = CS_IDLE;
				end
			end
			// region-two setup: ry^2*t^2 + 4*rx^2*u^2 - 4*rx^2*ry^2
			CS_R2_M1: begin
				cmd.mul_sel = MUL_TT;
				state_d     = CS_R2_M2;
			end
			CS_R2_M2: begin
				cmd.mul_sel = MUL_RY2TT;
				state_d     = CS_R2_M3;
			end
			CS_R2_M3: begin
				cmd.acc_load = 1'b1;
				cmd.mul_sel  = MUL_UU;
				state_d      = CS_R2_M4;
			end
			CS_R2_M4: begin
				cmd.mul_sel = MUL_RX2UU;
				state_d     = CS_R2_M5;
			end
			CS_R2_M5: begin
				cmd.acc_add = 1'b1;
				cmd.mul_sel = MUL_RX2RY2;
				state_d     = CS_R2_INIT;
			end
			CS_R2_INIT: begin
				cmd.r2_init = 1'b1;
				state_d     = status.y_pos ? CS_ITER : CS_FIN;
			end
			CS_ITER: begin
				cmd.iter = 1'b1;
				beat_d   = '0;
				state_d  = CS_EMIT;
			end
			// four mirror pixels, one beat each
			CS_EMIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.beat     = beat_q;
					cmd.out_last = (beat_q == LAST_BEAT);
					if (beat_q == LAST_BEAT) begin
						state_d = CS_IDLE;
					end else begin
						beat_d = beat_q + 1'b1;
					end
				end
			end
			CS_FIN: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_fin  = 1'b1;
					cmd.out_last = 1'b1;
					cmd.set_done = 1'b1;
					state_d      = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

endmodule

// File: rtl/mer_datapath.sv
`timescale 1ns / 1ps

module mer_datapath import mer_pkg::*; #(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mer_cmd_t                cmd,
	output mer_status_t             status,
	input  logic [RADIUS_BITS-1:0]  radius_x,
	input  logic [RADIUS_BITS-1:0]  radius_y,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic signed [PIX_W-1:0] pixel_x,
	output logic signed [PIX_W-1:0] pixel_y,
	output logic                    pixel_valid,
	output logic                    last_of_step,
	output logic                    finished
);

	localparam int R  = RADIUS_BITS;
	localparam int XW = R + 2;      // x coordinate
	localparam int YW = R;          // y coordinate
	localparam int QW = 2 * R;      // squared radius
	localparam int SW = 3 * R + 3;  // px, py
	localparam int DW = 4 * R + 8;  // decision, signed
	localparam int MA = 2 * R + 6;  // multiplier operand A
	localparam int MB = 2 * R;      // multiplier operand B
	localparam int PW = MA + MB;    // product
	localparam logic signed [DW-1:0] TRUNC_BIAS = 3;

	logic [R-1:0]  rx_q, ry_q;
	logic [QW-1:0] rx2_q, ry2_q;
	logic [PW-1:0] mul_q;
	logic signed [DW-1:0] acc_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [SW-1:0] px_q, py_q;
	logic signed [DW-1:0] dec_q;
	phase_t        phase_q;
	logic [CFG_W-1:0]        off_q;
	logic signed [CFG_W-1:0] cx_q, cy_q;
	logic                    res_valid_q;
	logic [PIX_W-1:0]        pix_x_q, pix_y_q;
	logic                    pix_valid_q, last_q, fin_q;

	// Divide by four, truncating toward zero
	function automatic logic signed [DW-1:0] quarter_trunc(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] b;
		b = v[DW-1] ? (v + TRUNC_BIAS) : v;
		return b >>> 2;
	endfunction

	// Multiplier operands
	logic [XW:0]   t_val;
	logic [YW-1:0] u_abs;
	logic [MA-1:0] op_a;
	logic [MB-1:0] op_b;

	assign t_val = {x_q, 1'b1};
	assign u_abs = (y_q == '0) ? YW'(1) : (y_q - 1'b1);

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.mul_sel)
			MUL_RXRX: begin
				op_a = MA'(rx_q);
				op_b = MB'(rx_q);
			end
			MUL_RYRY: begin
				op_a = MA'(ry_q);
				op_b = MB'(ry_q);
			end
			MUL_RX2RY: begin
				op_a = MA'(ry_q);
				op_b = rx2_q;
			end
			MUL_TT: begin
				op_a = MA'(t_val);
				op_b = MB'(t_val);
			end
			MUL_RY2TT: begin
				op_a = mul_q[MA-1:0];
				op_b = ry2_q;
			end
			MUL_UU: begin
				op_a = MA'(u_abs);
				op_b = MB'(u_abs);
			end
			MUL_RX2UU: begin
				op_a = mul_q[MA-1:0];
				op_b = rx2_q;
			end
			MUL_RX2RY2: begin
				op_a = MA'(ry2_q);
				op_b = rx2_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Shared multiplier, registered product
	always_ff @(posedge clk) begin
		mul_q <= op_a * op_b;
		if (cmd.in_load) begin
			rx_q <= radius_x;
			ry_q <= radius_y;
		end
		if (cmd.acc_load) begin
			acc_q <= $signed(DW'(mul_q));
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + $signed(DW'({mul_q, 2'b00}));
		end
	end

	// Iteration terms
	logic [SW-1:0] two_rx2, two_ry2, px_inc, py_dec;
	logic signed [DW-1:0] d_rx2, d_ry2, d_pxi, d_pyd;
	logic signed [DW-1:0] st_dec, r2_dec, it_dec;
	logic [XW-1:0] it_x;
	logic [YW-1:0] it_y;
	logic [SW-1:0] it_px, it_py;

	assign two_rx2 = SW'({rx2_q, 1'b0});
	assign two_ry2 = SW'({ry2_q, 1'b0});
	assign px_inc  = px_q + two_ry2;
	assign py_dec  = py_q - two_rx2;
	assign d_rx2   = $signed(DW'(rx2_q));
	assign d_ry2   = $signed(DW'(ry2_q));
	assign d_pxi   = $signed(DW'(px_inc));
	assign d_pyd   = $signed(DW'(py_dec));

	// Start decision from ry^2, rx^2 and the rx^2*ry product
	assign st_dec = quarter_trunc($signed(DW'({ry2_q, 2'b00}))
		- $signed(DW'({mul_q, 2'b00})) + d_rx2);
	// Region-two decision: accumulated terms minus 4*rx^2*ry^2
	assign r2_dec = quarter_trunc(acc_q - $signed(DW'({mul_q, 2'b00})));

	always_comb begin
		it_x   = x_q;
		it_y   = y_q;
		it_px  = px_q;
		it_py  = py_q;
		it_dec = dec_q;
		if (phase_q == PH_R1) begin
			it_x  = x_q + 1'b1;
			it_px = px_inc;
			if (dec_q < 0) begin
				it_dec = dec_q + d_ry2 + d_pxi;
			end else begin
				it_y   = y_q - 1'b1;
				it_py  = py_dec;
				it_dec = dec_q + d_ry2 + d_pxi - d_pyd;
			end
		end else begin
			it_y  = y_q - 1'b1;
			it_py = py_dec;
			if (dec_q > 0) begin
				it_dec = dec_q + d_rx2 - d_pyd;
			end else begin
				it_x   = x_q + 1'b1;
				it_px  = px_inc;
				it_dec = dec_q + d_rx2 - d_pyd + d_pxi;
			end
		end
	end

	// Ellipse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx2_q   <= '0;
			ry2_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			px_q    <= '0;
			py_q    <= '0;
			dec_q   <= '0;
			phase_q <= PH_IDLE;
		end else begin
			if (cmd.cap_rx2) begin
				rx2_q <= mul_q[QW-1:0];
			end
			if (cmd.cap_ry2) begin
				ry2_q <= mul_q[QW-1:0];
			end
			if (cmd.start_init) begin
				x_q     <= '0;
				y_q     <= ry_q;
				px_q    <= '0;
				py_q    <= SW'({mul_q, 1'b0});
				dec_q   <= st_dec;
				phase_q <= PH_R1;
			end else if (cmd.r2_init) begin
				dec_q   <= r2_dec;
				phase_q <= PH_R2;
			end else if (cmd.iter) begin
				x_q   <= it_x;
				y_q   <= it_y;
				px_q  <= it_px;
				py_q  <= it_py;
				dec_q <= it_dec;
			end else if (cmd.set_done && phase_q == PH_R2) begin
				phase_q <= PH_DONE;
			end
		end
	end

	// Config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= SCREEN_OFFSET_RST;
			cx_q  <= '0;
			cy_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCREEN_OFFSET: off_q <= cfg_data;
				CFG_CENTER_X:      cx_q  <= cfg_data;
				CFG_CENTER_Y:      cy_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Mirror pixel: beat bit 0 negates x, bit 1 negates y
	logic [PIX_W-1:0] xs, ys, sx, sy, base_x, base_y;

	assign xs     = PIX_W'(x_q);
	assign ys     = PIX_W'(y_q);
	assign sx     = cmd.beat[0] ? (PIX_W'(0) - xs) : xs;
	assign sy     = cmd.beat[1] ? (PIX_W'(0) - ys) : ys;
	assign base_x = PIX_W'(off_q) + PIX_W'(cx_q);
	assign base_y = PIX_W'(off_q) + PIX_W'(cy_q);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			last_q <= cmd.out_last;
			if (cmd.out_fin) begin
				pix_x_q     <= '0;
				pix_y_q     <= '0;
				pix_valid_q <= 1'b0;
				fin_q       <= 1'b1;
			end else begin
				pix_x_q     <= base_x + sx;
				pix_y_q     <= base_y + sy;
				pix_valid_q <= 1'b1;
				fin_q       <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign pixel_x      = $signed(pix_x_q);
	assign pixel_y      = $signed(pix_y_q);
	assign pixel_valid  = pix_valid_q;
	assign last_of_step = last_q;
	assign finished     = fin_q;

	// Status
	assign status.phase    = phase_q;
	assign status.px_lt_py = (px_q < py_q);
	assign status.y_pos    = (y_q != '0);
	assign status.out_free = !res_valid_q || res_ready;

endmodule

// File: rtl/midpoint_ellipse_rasterizer.sv
// Start item: after acceptance the multiply states and a setup state run, then the
// start pixel lands in the output register.
// Step item: an iteration state, then 4 pixel beats from one output register.
// A step entering region two first runs 5 shared-multiplier passes plus setup.
// No iteration left: a finished beat is loaded. No new item is taken before an item's
// last beat is loaded, which waits while a beat is held and res_ready is low. Async
// active-low reset: idle, coordinates zero, offset 250, centers zero.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer import mer_pkg::*; #(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  logic                    action,
	input  logic [RADIUS_BITS-1:0]  radius_x,
	input  logic [RADIUS_BITS-1:0]  radius_y,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic signed [PIX_W-1:0] pixel_x,
	output logic signed [PIX_W-1:0] pixel_y,
	output logic                    pixel_valid,
	output logic                    last_of_step,
	output logic                    finished
);

	mer_cmd_t    cmd;
	mer_status_t status;

	// Sequencer
	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.action    (action),
		.cmd_ready (cmd_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic, ellipse state, config and output register
	mer_datapath #(
		.RADIUS_BITS (RADIUS_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.radius_x     (radius_x),
		.radius_y     (radius_y),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_valid  (pixel_valid),
		.last_of_step (last_of_step),
		.finished     (finished)
	);

`ifndef SYNTH
	// Region two only runs once px has caught up with py
	a_r2_slope: assert property (@(posedge clk) disable iff (!arst_n)
		status.phase == PH_R2 |-> !status.px_lt_py)
		else $error("px below py in region two");

	// State updates and output loads never collide
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start_init, cmd.r2_init, cmd.iter, cmd.out_load}))
		else $error("overlapping datapath commands");

	// A pixel beat implies an ellipse has been started
	a_pix_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pixel_valid |-> status.phase != PH_IDLE)
		else $error("pixel emitted with no ellipse");

	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("item accepted while busy");
`endif

endmodule

// File: bench/ellipse_pixel_checker.sv
`timescale 1ns / 1ps

module ellipse_pixel_checker import mer_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  logic                       cmd_ready,
	input  logic                       action,
	input  logic [RADIUS_BITS_DEF-1:0] radius_x,
	input  logic [RADIUS_BITS_DEF-1:0] radius_y,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       res_valid,
	input  logic                       res_ready,
	input  logic signed [PIX_W-1:0]    pixel_x,
	input  logic signed [PIX_W-1:0]    pixel_y,
	input  logic                       pixel_valid,
	input  logic                       last_of_step,
	input  logic                       finished,
	output int                         fail_count,
	output int                         pending,
	output int                         checked
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;
		logic             valid;
		logic             last;
		logic             fin;
	} pixel_beat_t;

	// Pixels still owed by the block, oldest first
	pixel_beat_t pixel_q[$];
	pixel_beat_t got_beat, want_beat;
	int fails, nchecked;

	// Shadow registers
	logic [CFG_W-1:0]        scr_off;
	logic signed [CFG_W-1:0] cen_x, cen_y;

	// Shadow rasterizer state
	phase_t ph;
	longint cur_x, cur_y, slope_x, slope_y, dval, held_rx, held_ry;

	task automatic queue_beat(longint x, longint y, logic valid, logic last, logic fin);
		pixel_beat_t b;
		b.px = x[PIX_W-1:0];
		b.py = y[PIX_W-1:0];
		b.valid = valid;
		b.last = last;
		b.fin = fin;
		pixel_q.push_back(b);
	endtask

	// Pixel relative to the center, moved to screen space
	task automatic queue_pixel(longint x, longint y, logic last);
		longint bx, by;
		bx = longint'(scr_off) + longint'(cen_x);
		by = longint'(scr_off) + longint'(cen_y);
		queue_beat(bx + x, by + y, 1'b1, last, 1'b0);
	endtask

	task automatic queue_mirrors();
		queue_pixel(cur_x, cur_y, 1'b0);
		queue_pixel(-cur_x, cur_y, 1'b0);
		queue_pixel(cur_x, -cur_y, 1'b0);
		queue_pixel(-cur_x, -cur_y, 1'b1);
	endtask

	// One accepted command beat: advance the shadow state, queue its pixels
	task automatic rasterize_item(logic act, logic [RADIUS_BITS_DEF-1:0] rx_in,
		logic [RADIUS_BITS_DEF-1:0] ry_in);
		longint rx, ry, rx2, ry2, t, u;
		if (act == ACT_START) begin
			rx = longint'(rx_in);
			ry = longint'(ry_in);
			held_rx = rx;
			held_ry = ry;
			cur_x = 0;
			cur_y = ry;
			slope_x = 0;
			slope_y = 2 * rx * rx * ry;
			dval = (4 * ry * ry - 4 * rx * rx * ry + rx * rx) / 4;
			ph = PH_R1;
			queue_pixel(0, ry, 1'b1);
			return;
		end
		rx2 = held_rx * held_rx;
		ry2 = held_ry * held_ry;
		if (ph == PH_R1) begin
			if (slope_x < slope_y) begin
				cur_x += 1;
				slope_x += 2 * ry2;
				if (dval < 0) begin
					dval += ry2 + slope_x;
				end else begin
					cur_y -= 1;
					slope_y -= 2 * rx2;
					dval += ry2 + slope_x - slope_y;
				end
				queue_mirrors();
				return;
			end
			// region one over: exact quarter-unit start value, truncated
			t = 2 * cur_x + 1;
			u = cur_y - 1;
			dval = (ry2 * t * t + 4 * rx2 * u * u - 4 * rx2 * ry2) / 4;
			ph = PH_R2;
		end
		if (ph == PH_R2) begin
			if (cur_y > 0) begin
				cur_y -= 1;
				slope_y -= 2 * rx2;
				if (dval > 0) begin
					dval += rx2 - slope_y;
				end else begin
					cur_x += 1;
					slope_x += 2 * ry2;
					dval += rx2 - slope_y + slope_x;
				end
				queue_mirrors();
				return;
			end
			ph = PH_DONE;
		end
		// idle or done: a lone finished marker
		queue_beat(0, 0, 1'b0, 1'b1, 1'b1);
	endtask

	task automatic note_failure(string what, pixel_beat_t want, pixel_beat_t got);
		fails++;
		if (fails <= MAX_REPORTS)
			$display({"%0t %s: expected x=%0d y=%0d v=%0b l=%0b f=%0b,",
				" got x=%0d y=%0d v=%0b l=%0b f=%0b"},
				$realtime, what, $signed(want.px), $signed(want.py), want.valid, want.last,
				want.fin, $signed(got.px), $signed(got.py), got.valid, got.last, got.fin);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q.delete();
			fails = 0;
			nchecked = 0;
			scr_off = SCREEN_OFFSET_RST;
			cen_x = '0;
			cen_y = '0;
			ph = PH_IDLE;
			cur_x = 0;
			cur_y = 0;
			slope_x = 0;
			slope_y = 0;
			dval = 0;
			held_rx = 0;
			held_ry = 0;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// result beat against the oldest owed pixel
			if (res_valid && res_ready) begin
				got_beat = {pixel_x, pixel_y, pixel_valid, last_of_step, finished};
				if (pixel_q.size() == 0) begin
					note_failure("unexpected result", '0, got_beat);
				end else begin
					want_beat = pixel_q.pop_front();
					if (got_beat !== want_beat)
						note_failure("result mismatch", want_beat, got_beat);
				end
				nchecked++;
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SCREEN_OFFSET: scr_off = cfg_data;
					CFG_CENTER_X:      cen_x = cfg_data;
					CFG_CENTER_Y:      cen_y = cfg_data;
					default: ;
				endcase
			end
			// command beat
			if (cmd_valid && cmd_ready)
				rasterize_item(action, radius_x, radius_y);
			fail_count <= fails;
			pending <= pixel_q.size();
			checked <= nchecked;
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench import mer_pkg::*;;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_GAP      = 10;
	localparam int RANDOM_ITEMS = 65;
	localparam int N_PHASES     = 5;
	localparam int SMALL_R      = 12;
	localparam int SETTLE       = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic clk, arst_n;
	logic cmd_valid, cmd_ready, action;
	logic [RADIUS_BITS_DEF-1:0] radius_x, radius_y;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic res_valid, res_ready;
	logic signed [PIX_W-1:0] pixel_x, pixel_y;
	logic pixel_valid, last_of_step, finished;

	int fail_count, pending, checked;
	int items_sent, n_settings, cycles;
	bit quiet;

	midpoint_ellipse_rasterizer dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.action(action), .radius_x(radius_x), .radius_y(radius_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.res_valid(res_valid), .res_ready(res_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_valid(pixel_valid),
		.last_of_step(last_of_step), .finished(finished)
	);

	ellipse_pixel_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.action(action), .radius_x(radius_x), .radius_y(radius_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.res_valid(res_valid), .res_ready(res_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_valid(pixel_valid),
		.last_of_step(last_of_step), .finished(finished),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random stall before each beat
	initial begin
		int stall;
		res_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!(res_valid && res_ready));
		end
	end

	// One command beat, after a random gap
	task automatic send_item(logic act, logic [RADIUS_BITS_DEF-1:0] rx,
		logic [RADIUS_BITS_DEF-1:0] ry);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		action <= act;
		radius_x <= rx;
		radius_y <= ry;
		do @(posedge clk); while (!cmd_ready);
		items_sent++;
	endtask

	// Start beat followed by step beats; radii on steps are don't-care noise
	task automatic draw_ellipse(int rx, int ry, int nsteps);
		send_item(ACT_START, RADIUS_BITS_DEF'(rx), RADIUS_BITS_DEF'(ry));
		repeat (nsteps)
			send_item(ACT_STEP, RADIUS_BITS_DEF'($urandom), RADIUS_BITS_DEF'($urandom));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(int off, int cx, int cy);
		write_reg(CFG_SCREEN_OFFSET, CFG_W'(off));
		write_reg(CFG_CENTER_X, CFG_W'(cx));
		write_reg(CFG_CENTER_Y, CFG_W'(cy));
		write_reg(CFG_SPARE, CFG_W'($urandom_range(0, 511)));
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Let every owed pixel come out, then hold off for the SETTLE period
	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly small ellipses, walked to the end or cut short, some large ones cut short,
	// some stray steps
	task automatic random_group();
		int pick, rx, ry;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			send_item(ACT_STEP, RADIUS_BITS_DEF'($urandom), RADIUS_BITS_DEF'($urandom));
		end else if (pick == 1) begin
			draw_ellipse($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 12));
		end else begin
			rx = $urandom_range(0, SMALL_R);
			ry = $urandom_range(0, SMALL_R);
			if (pick < 6)
				draw_ellipse(rx, ry, rx + ry + 3);
			else
				draw_ellipse(rx, ry, $urandom_range(0, rx + ry + 3));
		end
	endtask

	initial begin
		int offs[4] = '{0, 511, 511, 0};
		int cxs[4]  = '{-256, 255, -256, 255};
		int cys[4]  = '{-256, 255, 255, -256};
		int target;
		items_sent = 0;
		n_settings = 0;
		quiet = 1'b0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		action <= ACT_START;
		radius_x <= '0;
		radius_y <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SCREEN_OFFSET;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset register values
		send_item(ACT_STEP, 8'hFF, 8'h00);   // steps while idle
		send_item(ACT_STEP, 8'h00, 8'hFF);
		draw_ellipse(0, 0, 1);               // both radii zero
		draw_ellipse(255, 0, 2);             // flat: done on first step, repeated
		draw_ellipse(0, 3, 4);               // thin: walks down the y axis
		draw_ellipse(255, 255, 2);           // largest, abandoned by next start
		draw_ellipse(4, 3, 9);               // full small ellipse plus repeated done steps
		drain();

		// Random, one register setting per phase
		for (int p = 0; p < N_PHASES; p++) begin
			if (p < 4)
				apply_setting(offs[p], cxs[p], cys[p]);
			else
				apply_setting($urandom_range(0, 511), $urandom_range(0, 511),
					$urandom_range(0, 511));
			quiet = (p == 2);
			target = items_sent + RANDOM_ITEMS / N_PHASES;
			while (items_sent < target)
				random_group();
			drain();
		end

		$display("Summary: %0d command beats over %0d register settings, %0d result beats checked.",
			items_sent, n_settings, checked);
		$display("Covered idle and done steps, zero radii, abandoned ellipses, radii up to 255.");
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/mer_pkg.sv
rtl/mer_ctrl.sv
rtl/mer_datapath.sv
rtl/midpoint_ellipse_rasterizer.sv
bench/ellipse_pixel_checker.sv
bench/testbench.sv
